/* sv/btb2_pkg.sv */
// Shared types and defaults for the 2-bit branch target buffer.
// Used by btb2_front, btb2_back and the top level; no dependencies.
package btb2_pkg;

  // Default table geometry
  localparam int unsigned EntriesDef     = 16;
  localparam int unsigned PointerBitsDef = 4;

  // One request beat: fetch lookup plus an optional resolved-branch update
  typedef struct packed {
    logic [31:0] fetch_address;
    logic        update_valid;
    logic        decode_queue_empty;
    logic [31:0] branch_address;
    logic [31:0] branch_destination;
    logic        prediction_correct;
  } req_t;

  // One response beat
  typedef struct packed {
    logic        predict_taken;
    logic [31:0] predicted_target;
  } rsp_t;

  // Classified job handed from the front queue to the back engine
  typedef struct packed {
    logic [31:0] fetch_address;
    logic        do_update;
    logic [31:0] branch_address;
    logic [31:0] branch_destination;
    logic        prediction_correct;
  } job_t;

  // Queue head status toward the back engine
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

/* sv/btb2_front.sv */
// Front end: accepts request beats, classifies the update and queues jobs.
// Depends on btb2_pkg.
module btb2_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  btb2_pkg::req_t  req_i,
  output btb2_pkg::head_t head_o,
  input  logic            pop_i
);
  import btb2_pkg::*;

  localparam int unsigned Depth = 2;

  job_t       mem_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  job_t       job_in;

  // Classify: an update only counts when the decode queue holds something
  always_comb begin
    job_in.fetch_address      = req_i.fetch_address;
    job_in.do_update          = req_i.update_valid & ~req_i.decode_queue_empty;
    job_in.branch_address     = req_i.branch_address;
    job_in.branch_destination = req_i.branch_destination;
    job_in.prediction_correct = req_i.prediction_correct;
  end

  assign busy = (count_q == 2'(Depth));
  assign push = start & ~busy;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the accepted beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= job_in;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.job   = mem_q[rd_ptr_q];

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(Depth)) else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != 2'd0)) else $error("pop from empty queue");
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (count_q != 2'd0)) else $error("queue empty after push");
`endif

endmodule

/* sv/btb2_back.sv */
// Back end: associative match, prediction and table update for one job.
// Depends on btb2_pkg; holds the entry table and the target memory.
module btb2_back #(
  parameter int unsigned ENTRIES      = btb2_pkg::EntriesDef,
  parameter int unsigned POINTER_BITS = btb2_pkg::PointerBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            predict_enable_i,
  input  btb2_pkg::head_t head_i,
  output logic            pop_o,
  output logic            valid_o,
  output btb2_pkg::rsp_t  rsp_o
);
  import btb2_pkg::*;

  localparam int unsigned IdxW = $clog2(ENTRIES);

  typedef enum logic [1:0] {
    CTR_SNT = 2'b00,
    CTR_WNT = 2'b01,
    CTR_WT  = 2'b10,
    CTR_ST  = 2'b11
  } ctr_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_e;

  function automatic ctr_e ctr_step(ctr_e c, logic up);
    ctr_e r;
    r = c;
    case (c)
      CTR_SNT: r = up ? CTR_WNT : CTR_SNT;
      CTR_WNT: r = up ? CTR_WT  : CTR_SNT;
      CTR_WT:  r = up ? CTR_ST  : CTR_WNT;
      CTR_ST:  r = up ? CTR_ST  : CTR_WT;
      default: r = c;
    endcase
    return r;
  endfunction

  state_e                  state_q, state_d;
  job_t                    job_q;
  logic [ENTRIES-1:0]      fmatch_q, bmatch_q;
  logic [31:0]             baddr_q [ENTRIES];
  ctr_e                    ctr_q [ENTRIES];
  logic [ENTRIES-1:0]      valid_q;
  logic [31:0]             tgt_mem [ENTRIES];
  logic [POINTER_BITS-1:0] ptr_q, ptr_d;

  logic                    out_valid_q;
  logic                    taken_q;
  logic                    hit_valid_q;
  logic [31:0]             tgt_rd_q;

  logic                    fhit, bhit;
  logic [IdxW-1:0]         hit_idx;
  logic [ENTRIES-1:0]      bfirst;
  logic                    seen;
  logic                    do_upd, do_train, do_alloc, alloc_wr;
  logic [POINTER_BITS:0]   ptr_inc;
  logic [31:0]             ptr_wide;
  logic [IdxW-1:0]         wr_idx;

  // Take a job whenever the engine is free
  assign pop_o = (state_q == S_IDLE) && head_i.valid;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (head_i.valid) state_d = S_UPDATE;
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Find the lowest matching entry for the lookup and the update
  always_comb begin
    fhit    = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (fmatch_q[i]) begin
        fhit    = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
    seen = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      bfirst[i] = bmatch_q[i] & ~seen;
      seen      = seen | bmatch_q[i];
    end
    bhit = seen;
  end

  // Replacement pointer: advance with wrap at the table size
  always_comb begin
    ptr_inc  = {1'b0, ptr_q} + {{POINTER_BITS{1'b0}}, 1'b1};
    ptr_wide = 32'(ptr_q);
    wr_idx   = ptr_wide[IdxW-1:0];
    do_upd   = (state_q == S_UPDATE) && job_q.do_update;
    do_train = do_upd && bhit;
    do_alloc = do_upd && !bhit;
    alloc_wr = do_alloc && (ptr_wide < 32'(ENTRIES));
    ptr_d    = ptr_q;
    if (do_alloc) begin
      ptr_d = (32'(ptr_inc) >= 32'(ENTRIES)) ? '0 : ptr_inc[POINTER_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        baddr_q[i] <= '0;
        ctr_q[i]   <= CTR_SNT;
      end
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= (state_q == S_UPDATE);
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_train && bfirst[i]) begin
          ctr_q[i] <= ctr_step(ctr_q[i], job_q.prediction_correct);
        end else if (alloc_wr && (wr_idx == IdxW'(i))) begin
          baddr_q[i] <= job_q.branch_address;
          ctr_q[i]   <= CTR_WT;
          valid_q[i] <= 1'b1;
        end
      end
    end
  end

  // Latch the job and compare it against every entry
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i.job;
      for (int i = 0; i < ENTRIES; i++) begin
        fmatch_q[i] <= (baddr_q[i] == head_i.job.fetch_address);
        bmatch_q[i] <= (baddr_q[i] == head_i.job.branch_address);
      end
    end
  end

  // Target memory: read old contents for the lookup, write on allocation
  always_ff @(posedge clk_i) begin
    if (alloc_wr) begin
      tgt_mem[wr_idx] <= job_q.branch_destination;
    end
    if (state_q == S_UPDATE) begin
      tgt_rd_q <= tgt_mem[hit_idx];
    end
  end

  // Hold prediction flags for the result beat
  always_ff @(posedge clk_i) begin
    if (state_q == S_UPDATE) begin
      taken_q     <= predict_enable_i & fhit & ctr_q[hit_idx][1];
      hit_valid_q <= fhit & valid_q[hit_idx];
    end
  end

  assign valid_o                = out_valid_q;
  assign rsp_o.predict_taken    = taken_q;
  assign rsp_o.predicted_target = hit_valid_q ? tgt_rd_q : 32'd0;

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |=> out_valid_q) else $error("missing result beat");
  a_one_cycle_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |=> (state_q == S_IDLE)) else $error("job overran");
  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !do_alloc |=> $stable(ptr_q)) else $error("pointer moved without alloc");
`endif

endmodule

/* sv/branch_target_buffer_2bit_unit.sv */
// An accepted beat is queued, then latched with its match flags, then updated and registered as the result beat.
// The back engine takes a new request only once its match-then-update pair for the last one is done.
// A 2-deep request queue lets start be taken while the engine works; busy is high when full.
// Reset clears all entries (address 0, strongly not taken), the pointer, and enables
// prediction; results last one cycle on valid_o and cannot be stalled.
module branch_target_buffer_2bit_unit #(
  parameter int unsigned ENTRIES      = btb2_pkg::EntriesDef,
  parameter int unsigned POINTER_BITS = btb2_pkg::PointerBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  btb2_pkg::req_t req_i,
  output logic           valid_o,
  output btb2_pkg::rsp_t rsp_o,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i
);
  import btb2_pkg::*;

  logic  predict_enable_q;
  head_t head;
  logic  pop;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      predict_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      predict_enable_q <= cfg_wdata_i;
    end
  end

  btb2_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .head_o (head),
    .pop_i  (pop)
  );

  btb2_back #(
    .ENTRIES      (ENTRIES),
    .POINTER_BITS (POINTER_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .predict_enable_i (predict_enable_q),
    .head_i           (head),
    .pop_o            (pop),
    .valid_o          (valid_o),
    .rsp_o            (rsp_o)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for branch_target_buffer_2bit_unit.
// Depends on btb2_pkg for the request and response beat types.
// Holds an in-file table shadow that predicts each lookup and checks results in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btb2_pkg::*;

  localparam int unsigned NUM_ENTRIES = EntriesDef;
  localparam int unsigned PTR_BITS    = PointerBitsDef;
  localparam int          RANDOM_BEATS = 700;
  localparam int          CYCLE_LIMIT  = 100000;
  localparam int          POOL_SIZE    = 20;

  // 2-bit saturating counter encoding
  typedef enum logic [1:0] {
    CTR_STRONG_NT = 2'd0,
    CTR_WEAK_NT   = 2'd1,
    CTR_WEAK_T    = 2'd2,
    CTR_STRONG_T  = 2'd3
  } ctr_e;

  // Shadow of the branch table: predicts one lookup per accepted beat
  class btb_shadow;
    logic [31:0]         tag_addr [NUM_ENTRIES];
    logic [31:0]         dest_addr[NUM_ENTRIES];
    ctr_e                ctr      [NUM_ENTRIES];
    logic [PTR_BITS-1:0] victim_ptr;
    bit                  taken_allowed;
    rsp_t                lookup_q[$];
    int                  mismatches;
    int                  lookups;
    int                  hits;
    int                  taken_seen;
    int                  allocations;
    int                  trainings;

    function new();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        tag_addr[i]  = '0;
        dest_addr[i] = '0;
        ctr[i]       = CTR_STRONG_NT;
      end
      victim_ptr    = '0;
      taken_allowed = 1'b1;
      mismatches    = 0;
      lookups       = 0;
      hits          = 0;
      taken_seen    = 0;
      allocations   = 0;
      trainings     = 0;
    endfunction

    function void set_predict(bit on);
      taken_allowed = on;
    endfunction

    // Lowest-numbered matching entry, -1 on a miss
    function int find_tag(logic [31:0] addr);
      int found;
      found = -1;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (found < 0 && tag_addr[i] == addr) found = i;
      end
      return found;
    endfunction

    // Look up against the old table, then apply the resolved-branch update
    function void note_fetch(req_t beat);
      rsp_t                exp_rsp;
      int                  hit_idx;
      int                  upd_idx;
      logic [PTR_BITS:0]   next_ptr;
      exp_rsp = '0;
      hit_idx = find_tag(beat.fetch_address);
      if (hit_idx >= 0) begin
        exp_rsp.predicted_target = dest_addr[hit_idx];
        exp_rsp.predict_taken    = taken_allowed &&
            (ctr[hit_idx] == CTR_WEAK_T || ctr[hit_idx] == CTR_STRONG_T);
        hits++;
      end
      if (exp_rsp.predict_taken) taken_seen++;
      lookups++;
      lookup_q.push_back(exp_rsp);

      if (beat.update_valid && !beat.decode_queue_empty) begin
        upd_idx = find_tag(beat.branch_address);
        if (upd_idx >= 0) begin
          trainings++;
          if (beat.prediction_correct) begin
            if (ctr[upd_idx] != CTR_STRONG_T) ctr[upd_idx] = ctr_e'(ctr[upd_idx] + 2'd1);
          end else begin
            if (ctr[upd_idx] != CTR_STRONG_NT) ctr[upd_idx] = ctr_e'(ctr[upd_idx] - 2'd1);
          end
        end else begin
          allocations++;
          if (victim_ptr < NUM_ENTRIES) begin
            tag_addr[victim_ptr]  = beat.branch_address;
            dest_addr[victim_ptr] = beat.branch_destination;
            ctr[victim_ptr]       = CTR_WEAK_T;
          end
          next_ptr = {1'b0, victim_ptr} + 1'b1;
          if (next_ptr >= NUM_ENTRIES) next_ptr = '0;
          victim_ptr = next_ptr[PTR_BITS-1:0];
        end
      end
    endfunction

    // Compare one result beat with the oldest predicted lookup
    function void check_lookup(rsp_t got);
      rsp_t want;
      if (lookup_q.size() == 0) begin
        $display("%0t: unexpected result beat, got taken=%0b target=%08h",
                 $time, got.predict_taken, got.predicted_target);
        mismatches++;
        return;
      end
      want = lookup_q.pop_front();
      if (got.predict_taken !== want.predict_taken) begin
        $display("%0t: predict_taken mismatch, expected %0b got %0b",
                 $time, want.predict_taken, got.predict_taken);
        mismatches++;
      end
      if (got.predicted_target !== want.predicted_target) begin
        $display("%0t: predicted_target mismatch, expected %08h got %08h",
                 $time, want.predicted_target, got.predicted_target);
        mismatches++;
      end
    endfunction

    function int pending();
      return lookup_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic valid_o;
  rsp_t rsp_o;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  btb_shadow   shadow = new();
  bit          gaps_on = 1'b1;
  int          cycles = 0;
  logic [31:0] addr_pool[POOL_SIZE];

  branch_target_buffer_2bit_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .valid_o     (valid_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, shadow.pending());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Check result beats first, then note the accepted request beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) shadow.check_lookup(rsp_o);
      if (start && !busy) shadow.note_fetch(req_i);
    end
  end

  // Present one request beat, with an occasional idle gap ahead of it
  task automatic drive_beat(input req_t beat);
    int gap;
    if (gaps_on && $urandom_range(99) < 38) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= beat;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send(input logic [31:0] fetch, input logic upd, input logic qempty,
                      input logic [31:0] baddr, input logic [31:0] bdest, input logic ok);
    req_t beat;
    beat.fetch_address      = fetch;
    beat.update_valid       = upd;
    beat.decode_queue_empty = qempty;
    beat.branch_address     = baddr;
    beat.branch_destination = bdest;
    beat.prediction_correct = ok;
    drive_beat(beat);
  endtask

  // Drain all outstanding lookups, then write the enable register
  task automatic set_predict(input logic on);
    @(negedge clk_i);
    start <= 1'b0;
    while (shadow.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.set_predict(on);
  endtask

  // Mostly pooled addresses so lookups hit and the table wraps; some noise
  function automatic req_t random_beat();
    req_t beat;
    beat.fetch_address = ($urandom_range(99) < 80) ?
        addr_pool[$urandom_range(POOL_SIZE - 1)] : $urandom();
    beat.update_valid       = ($urandom_range(99) < 70);
    beat.decode_queue_empty = ($urandom_range(99) < 20);
    beat.branch_address = ($urandom_range(99) < 85) ?
        addr_pool[$urandom_range(POOL_SIZE - 1)] : $urandom();
    beat.branch_destination = $urandom();
    beat.prediction_correct = 1'($urandom_range(1));
    return beat;
  endfunction

  initial begin
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom();

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_predict(1'b1);

    // Reset table holds address 0: fetch 0 hits, updates to 0 train entry 0
    send(32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send(32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    // Blocked update while the decode queue is empty
    send(32'h0000_0000, 1'b1, 1'b1, 32'h0000_1234, 32'h0000_5678, 1'b1);
    // Allocate into entry 0, new entry starts weakly taken
    send(32'h0000_1234, 1'b1, 1'b0, 32'h0000_1000, 32'hFFFF_FFFF, 1'b0);
    send(32'h0000_1000, 1'b1, 1'b0, 32'h0000_1000, 32'h0000_0000, 1'b1);
    send(32'h0000_1000, 1'b1, 1'b0, 32'h0000_1000, 32'h0000_0000, 1'b1);
    // Fetch 0 now matches several zero entries: lowest one wins
    send(32'h0000_0000, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    send(32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 32'h0000_ABCD, 1'b1);
    // Walk the counter down and hold at strongly not taken
    send(32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_1000, 32'h0000_0000, 1'b0);
    send(32'h0000_1000, 1'b1, 1'b0, 32'h0000_1000, 32'h0000_0000, 1'b0);
    send(32'h0000_1000, 1'b1, 1'b0, 32'h0000_1000, 32'h0000_0000, 1'b0);
    send(32'h0000_1000, 1'b1, 1'b0, 32'h0000_1000, 32'h0000_0000, 1'b0);
    send(32'h0000_1000, 1'b0, 1'b0, 32'h0000_1000, 32'hFFFF_FFFF, 1'b1);
    send(32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send(32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send(32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);

    // Prediction off: hits still give targets, never taken
    set_predict(1'b0);
    send(32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    send(32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send(32'h0000_0000, 1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send(32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);
    set_predict(1'b1);
    send(32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send(32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);

    // Random traffic with a gap-free stretch and a prediction-off window
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      gaps_on = !(n >= 150 && n < 300);
      if (n == 350) set_predict(1'b0);
      if (n == 420) set_predict(1'b1);
      if ($urandom_range(99) < 5) addr_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom();
      drive_beat(random_beat());
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (shadow.pending() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d lookups (%0d hits, %0d taken), %0d allocations, %0d trainings,",
             shadow.lookups, shadow.hits, shadow.taken_seen, shadow.allocations,
             shadow.trainings);
    $display("with prediction switched off and back on; %0d mismatches.", shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
